// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. All are clocked on clk and are switched
// off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge.
`define OHASH_CHECK(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that holds in the same cycle as its trigger.
`define OHASH_IMPLY(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) else $error(msg);

// A condition that holds in the cycle after its trigger.
`define OHASH_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// File: hdl/ohash_pkg.sv
// ---------------------------------------------------------------------------
// ohash_pkg
// Fixed field widths, request and status codes and the stored entry layout
// of the open-addressing hash table.
// ---------------------------------------------------------------------------
package ohash_pkg;

  localparam int KEY_BITS   = 32;
  localparam int HASH_BITS  = 32;
  localparam int VALUE_BITS = 32;

  // Input tdata: key, key_hash, value from the lowest bit up, padded to bytes.
  localparam int IN_DW = ((KEY_BITS + HASH_BITS + VALUE_BITS + 7) / 8) * 8;

  localparam logic [1:0] REQ_GET = 2'd0;
  localparam logic [1:0] REQ_SET = 2'd1;
  localparam logic [1:0] REQ_DEL = 2'd2;
  localparam logic [1:0] REQ_NOP = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BAD_VALUE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Payload of one slot; only meaningful while the slot is marked valid.
  typedef struct packed {
    logic [HASH_BITS-1:0]  hash;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

endpackage

// File: hdl/ohash_store.sv
// ---------------------------------------------------------------------------
// ohash_store
// Slot storage: a metadata memory (valid flag and skip count) and a payload
// memory (hash, key, value), each with one write and one registered read.
// ---------------------------------------------------------------------------
module ohash_store
  import ohash_pkg::*;
#(
  parameter int TABLE_SLOTS = 64
) (
  input  logic clk,
  input  logic [$clog2(TABLE_SLOTS)*3+$clog2(TABLE_SLOTS)+4+HASH_BITS+KEY_BITS+VALUE_BITS-1:0]
               mem_req,
  output logic [$clog2(TABLE_SLOTS)+2+HASH_BITS+KEY_BITS+VALUE_BITS-1:0] mem_rsp
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int SKIP_W = SLOT_W + 1;

  typedef struct packed {
    logic              valid;
    logic [SKIP_W-1:0] skips;
  } meta_t;

  typedef struct packed {
    logic [SLOT_W-1:0] rd_addr;
    logic              meta_we;
    logic [SLOT_W-1:0] meta_addr;
    meta_t             meta;
    logic              data_we;
    logic [SLOT_W-1:0] data_addr;
    entry_t            data;
  } mem_req_t;

  typedef struct packed {
    meta_t  meta;
    entry_t data;
  } mem_rsp_t;

  mem_req_t req;
  mem_rsp_t rsp_r;

  meta_t  meta_mem [TABLE_SLOTS];
  entry_t data_mem [TABLE_SLOTS];

  assign req     = mem_req;
  assign mem_rsp = rsp_r;

  // Both memories share the read address, so one block registers the pair.
  always_ff @(posedge clk) begin
    if (req.meta_we) begin
      meta_mem[req.meta_addr] <= req.meta;
    end
    if (req.data_we) begin
      data_mem[req.data_addr] <= req.data;
    end
    rsp_r.meta <= meta_mem[req.rd_addr];
    rsp_r.data <= data_mem[req.rd_addr];
  end

endmodule

// File: hdl/ohash_ctrl.sv
// ---------------------------------------------------------------------------
// ohash_ctrl
// Probe sequencer: clears the metadata after reset, walks the probe chain one
// slot a cycle and performs the read-modify-write passes of set and remove.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ohash_ctrl
  import ohash_pkg::*;
#(
  parameter int TABLE_SLOTS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic [1:0]             req_type,
  input  logic [KEY_BITS-1:0]    req_key,
  input  logic [HASH_BITS-1:0]   req_hash,
  input  logic [VALUE_BITS-1:0]  req_value,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [2+VALUE_BITS+$clog2(TABLE_SLOTS)-1:0] res,
  output logic [$clog2(TABLE_SLOTS)*3+$clog2(TABLE_SLOTS)+4+HASH_BITS+KEY_BITS+VALUE_BITS-1:0]
                                 mem_req,
  input  logic [$clog2(TABLE_SLOTS)+2+HASH_BITS+KEY_BITS+VALUE_BITS-1:0] mem_rsp
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int SKIP_W = SLOT_W + 1;
  localparam int CNT_W  = SLOT_W + 1;

  typedef struct packed {
    logic              valid;
    logic [SKIP_W-1:0] skips;
  } meta_t;

  typedef struct packed {
    logic [SLOT_W-1:0] rd_addr;
    logic              meta_we;
    logic [SLOT_W-1:0] meta_addr;
    meta_t             meta;
    logic              data_we;
    logic [SLOT_W-1:0] data_addr;
    entry_t            data;
  } mem_req_t;

  typedef struct packed {
    meta_t  meta;
    entry_t data;
  } mem_rsp_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] read_value;
    logic [SLOT_W-1:0]     slot;
  } res_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_LOOK  = 6'b000100,
    S_INS   = 6'b001000,
    S_DEL   = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]     clr_r, clr_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]     i_r, i_nxt;
  logic [SLOT_W-1:0]     start_r, start_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic [1:0]            type_r, type_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [HASH_BITS-1:0]  hash_r, hash_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  res_t                  res_r, res_nxt;

  mem_req_t          mreq;
  mem_rsp_t          rsp;
  logic [SLOT_W-1:0] step_i;
  logic              hit;

  // Probe step (5*i + 1) mod TABLE_SLOTS; the truncation is the modulo.
  function automatic logic [SLOT_W-1:0] probe_step(input logic [SLOT_W-1:0] i);
    probe_step = (i << 2) + i + SLOT_W'(1);
  endfunction

  assign rsp     = mem_rsp;
  assign mem_req = mreq;
  assign res     = res_r;
  assign step_i  = probe_step(i_r);
  assign hit     = rsp.meta.valid && (rsp.data.hash == hash_r) && (rsp.data.key == key_r);

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    start_nxt = start_r;
    idx_nxt   = idx_r;
    type_nxt  = type_r;
    key_nxt   = key_r;
    hash_nxt  = hash_r;
    val_nxt   = val_r;
    res_nxt   = res_r;

    mreq.rd_addr   = i_r;
    mreq.meta_we   = 1'b0;
    mreq.meta_addr = i_r;
    mreq.meta      = rsp.meta;
    mreq.data_we   = 1'b0;
    mreq.data_addr = i_r;
    mreq.data      = '{hash: hash_r, key: key_r, value: val_r};

    unique case (state_r)
      S_CLEAR: begin
        mreq.meta_we   = 1'b1;
        mreq.meta_addr = clr_r;
        mreq.meta      = '0;
        clr_nxt        = clr_r + SLOT_W'(1);
        if (clr_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        mreq.rd_addr = req_hash[SLOT_W-1:0];
        if (req_valid) begin
          type_nxt  = req_type;
          key_nxt   = req_key;
          hash_nxt  = req_hash;
          val_nxt   = req_value;
          start_nxt = req_hash[SLOT_W-1:0];
          i_nxt     = req_hash[SLOT_W-1:0];
          res_nxt   = '{status: ST_OK, read_value: '0, slot: '0};
          unique case (req_type) inside
            REQ_GET, REQ_DEL: begin
              state_nxt = S_LOOK;
            end
            REQ_SET: begin
              if (req_value == '0) begin
                res_nxt.status = ST_BAD_VALUE;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_LOOK;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_LOOK: begin
        if (hit) begin
          unique case (type_r)
            REQ_GET: begin
              res_nxt   = '{status: ST_OK, read_value: rsp.data.value, slot: i_r};
              state_nxt = S_RESP;
            end
            REQ_SET: begin
              mreq.data_we = 1'b1;
              res_nxt      = '{status: ST_OK, read_value: '0, slot: i_r};
              state_nxt    = S_RESP;
            end
            REQ_DEL: begin
              idx_nxt      = i_r;
              i_nxt        = start_r;
              mreq.rd_addr = start_r;
              state_nxt    = S_DEL;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end else if ((rsp.meta.skips == '0) || (step_i == start_r)) begin
          if (type_r != REQ_SET) begin
            res_nxt   = '{status: ST_NOT_FOUND, read_value: '0, slot: '0};
            state_nxt = S_RESP;
          end else if (cnt_r == CNT_W'(TABLE_SLOTS)) begin
            res_nxt   = '{status: ST_FULL, read_value: '0, slot: '0};
            state_nxt = S_RESP;
          end else begin
            i_nxt        = start_r;
            mreq.rd_addr = start_r;
            state_nxt    = S_INS;
          end
        end else begin
          i_nxt        = step_i;
          mreq.rd_addr = step_i;
        end
      end

      S_INS: begin
        mreq.meta_we = 1'b1;
        if (!rsp.meta.valid) begin
          // First free slot: claim it and keep its own skip count.
          mreq.meta    = '{valid: 1'b1, skips: rsp.meta.skips};
          mreq.data_we = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
          res_nxt      = '{status: ST_OK, read_value: '0, slot: i_r};
          state_nxt    = S_RESP;
        end else begin
          mreq.meta = '{valid: 1'b1, skips: rsp.meta.skips + SKIP_W'(1)};
          if (step_i == start_r) begin
            res_nxt   = '{status: ST_FULL, read_value: '0, slot: '0};
            state_nxt = S_RESP;
          end else begin
            i_nxt        = step_i;
            mreq.rd_addr = step_i;
          end
        end
      end

      S_DEL: begin
        mreq.meta_we = 1'b1;
        if (i_r == idx_r) begin
          mreq.meta = '{valid: 1'b0, skips: rsp.meta.skips};
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          res_nxt   = '{status: ST_OK, read_value: '0, slot: i_r};
          state_nxt = S_RESP;
        end else begin
          mreq.meta.valid = rsp.meta.valid;
          mreq.meta.skips = (rsp.meta.skips == '0) ? '0 : rsp.meta.skips - SKIP_W'(1);
          i_nxt           = step_i;
          mreq.rd_addr    = step_i;
        end
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    start_r <= start_nxt;
    idx_r   <= idx_nxt;
    type_r  <= type_nxt;
    key_r   <= key_nxt;
    hash_r  <= hash_nxt;
    val_r   <= val_nxt;
    res_r   <= res_nxt;
  end

  `OHASH_CHECK(a_count_range, cnt_r <= CNT_W'(TABLE_SLOTS), "entry count beyond table size")
  `OHASH_IMPLY(a_skip_headroom, (state_r == S_INS) && rsp.meta.valid, rsp.meta.skips != '1, "skip count about to wrap")
  `OHASH_IMPLY(a_remove_path_skips, (state_r == S_DEL) && (i_r != idx_r), rsp.meta.skips != '0, "remove path slot without a skip")
  `OHASH_NEXT(a_insert_counts, (state_r == S_INS) && !rsp.meta.valid, (state_r == S_RESP) && (cnt_r == $past(cnt_r) + CNT_W'(1)), "insert did not count the entry")

endmodule

// File: hdl/open_addressing_hash_table.sv
// ---------------------------------------------------------------------------
// open_addressing_hash_table
// Key/value table with open addressing and per-slot skip counts.
// ---------------------------------------------------------------------------
// Each request is a get, set or remove on a table of TABLE_SLOTS slots (a
// power of two). The probe starts at the slot given by the low bits of
// key_hash and steps to (5*i + 1) mod TABLE_SLOTS, one slot per clock cycle,
// since every step is one read through the slot memory's single read port.
// A request passes through its input transfer, the probe of P slots and a
// step in which the result moves to the output register once it is free.
// P is the number of slots looked at, which is 1 for a get or overwriting
// set that hits at its home slot. A set that inserts adds a second walk from
// the home slot to the first free slot, and a remove adds a walk from the
// home slot to the found slot, both inclusive and at one slot per cycle with
// the skip count updated in the same cycle. A set with a zero value and the
// reserved request code go straight to the result without touching memory.
// After reset the block clears the metadata of every slot, during which
// in_tready stays low. Exactly one result transfer follows every input
// transfer, in order; a finished result waits in the output register, so
// the next request is taken while it is still unread.
// ---------------------------------------------------------------------------
module open_addressing_hash_table
  import ohash_pkg::*;
#(
  parameter int TABLE_SLOTS = 64,
  localparam int SLOT_W = $clog2(TABLE_SLOTS),
  localparam int OUT_DW = ((VALUE_BITS + SLOT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_tvalid,
  output logic              in_tready,
  // key [31:0], key_hash [63:32], value [95:64]
  input  logic [IN_DW-1:0]  in_tdata,
  // req_type [1:0]
  input  logic [1:0]        in_tuser,

  output logic              out_tvalid,
  input  logic              out_tready,
  // read_value [31:0], slot_index [SLOT_W+31:32], zero padding above
  output logic [OUT_DW-1:0] out_tdata,
  // status [1:0]
  output logic [1:0]        out_tuser
);

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] read_value;
    logic [SLOT_W-1:0]     slot;
  } res_t;

  localparam int REQ_W = SLOT_W * 4 + 4 + HASH_BITS + KEY_BITS + VALUE_BITS;
  localparam int RSP_W = SLOT_W + 2 + HASH_BITS + KEY_BITS + VALUE_BITS;

  logic [KEY_BITS-1:0]   in_key;
  logic [HASH_BITS-1:0]  in_hash;
  logic [VALUE_BITS-1:0] in_value;

  logic       res_valid;
  logic       res_ready;
  res_t       res;
  logic [REQ_W-1:0] mem_req;
  logic [RSP_W-1:0] mem_rsp;

  // Output register: holds one result until its transfer completes.
  logic out_tvalid_r;
  res_t out_res_r;

  assign in_key   = in_tdata[KEY_BITS-1:0];
  assign in_hash  = in_tdata[KEY_BITS+HASH_BITS-1:KEY_BITS];
  assign in_value = in_tdata[KEY_BITS+HASH_BITS+VALUE_BITS-1:KEY_BITS+HASH_BITS];

  ohash_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_type  (in_tuser),
    .req_key   (in_key),
    .req_hash  (in_hash),
    .req_value (in_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp)
  );

  ohash_store #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp)
  );

  // The sequencer may hand over a result whenever the register is empty or
  // its content leaves in the same cycle.
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = OUT_DW'({out_res_r.slot, out_res_r.read_value});

endmodule

// File: tb/ohash_table_monitor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ohash_table_monitor
// Watches both streams of the hash table, keeps its own copy of the table
// and compares every result transfer with the answer it predicts.
// ---------------------------------------------------------------------------
module ohash_table_monitor
  import ohash_pkg::*;
#(
  parameter int TABLE_SLOTS = 64,
  localparam int SLOT_W = $clog2(TABLE_SLOTS),
  localparam int OUT_DW = ((VALUE_BITS + SLOT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic [1:0]        in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,
  input  logic [1:0]        out_tuser,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                full_seen,
  output int                longest_chain
);

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] read_value;
    logic [SLOT_W-1:0]     slot_index;
  } answer_t;

  answer_t answers_due[$];

  // Model copy of the table.
  bit                    slot_live  [TABLE_SLOTS];
  logic [HASH_BITS-1:0]  slot_hash  [TABLE_SLOTS];
  logic [KEY_BITS-1:0]   slot_key   [TABLE_SLOTS];
  logic [VALUE_BITS-1:0] slot_value [TABLE_SLOTS];
  int unsigned           slot_skips [TABLE_SLOTS];
  int unsigned           live_entries;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i);
    return SLOT_W'(i * 5 + 1);
  endfunction

  // The step sequence has full period, so TABLE_SLOTS steps is one whole wrap.
  function automatic bit find_slot(input logic [KEY_BITS-1:0] key,
                                   input logic [HASH_BITS-1:0] hash,
                                   output logic [SLOT_W-1:0] where);
    logic [SLOT_W-1:0] i;
    where = '0;
    if (live_entries == 0) return 1'b0;
    i = hash[SLOT_W-1:0];
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (slot_live[i] && slot_hash[i] == hash && slot_key[i] == key) begin
        where = i;
        return 1'b1;
      end
      if (slot_skips[i] == 0) return 1'b0;
      i = next_slot(i);
    end
    return 1'b0;
  endfunction

  // Applies one request to the model table and returns the answer it gives.
  function automatic answer_t serve(input logic [1:0] req,
                                    input logic [KEY_BITS-1:0] key,
                                    input logic [HASH_BITS-1:0] hash,
                                    input logic [VALUE_BITS-1:0] val);
    answer_t           a;
    logic [SLOT_W-1:0] where;
    logic [SLOT_W-1:0] free_slot;
    logic [SLOT_W-1:0] i;
    bit                hit;
    bit                free_found;
    int                path_len;
    a = '0;
    a.status = ST_OK;
    hit = find_slot(key, hash, where);
    case (req)
      REQ_GET: begin
        if (!hit) begin
          a.status = ST_NOT_FOUND;
        end else begin
          a.read_value = slot_value[where];
          a.slot_index = where;
        end
      end
      REQ_SET: begin
        if (val == '0) begin
          a.status = ST_BAD_VALUE;
        end else if (hit) begin
          slot_value[where] = val;
          a.slot_index = where;
        end else if (live_entries >= TABLE_SLOTS) begin
          a.status = ST_FULL;
        end else begin
          free_found = 1'b0;
          free_slot = '0;
          i = hash[SLOT_W-1:0];
          for (int n = 0; n < TABLE_SLOTS && !free_found; n++) begin
            if (!slot_live[i]) begin
              free_found = 1'b1;
              free_slot = i;
            end else begin
              i = next_slot(i);
            end
          end
          if (!free_found) begin
            a.status = ST_FULL;
          end else begin
            // Every occupied slot passed on the way gains a skip.
            i = hash[SLOT_W-1:0];
            path_len = 1;
            while (i != free_slot) begin
              slot_skips[i]++;
              i = next_slot(i);
              path_len++;
            end
            if (path_len > longest_chain) longest_chain = path_len;
            slot_live[free_slot] = 1'b1;
            slot_hash[free_slot] = hash;
            slot_key[free_slot] = key;
            slot_value[free_slot] = val;
            live_entries++;
            a.slot_index = free_slot;
          end
        end
      end
      REQ_DEL: begin
        if (!hit) begin
          a.status = ST_NOT_FOUND;
        end else begin
          i = hash[SLOT_W-1:0];
          for (int n = 0; n < TABLE_SLOTS && i != where; n++) begin
            if (slot_skips[i] > 0) slot_skips[i]--;
            i = next_slot(i);
          end
          slot_live[where] = 1'b0;
          slot_hash[where] = '0;
          slot_key[where] = '0;
          slot_value[where] = '0;
          if (live_entries > 0) live_entries--;
          a.slot_index = where;
        end
      end
      default: begin
        // Reserved code: no operation, all-zero answer.
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin : watch
    answer_t due;
    logic [VALUE_BITS-1:0] got_value;
    logic [SLOT_W-1:0]     got_slot;
    if (!rst_n) begin
      answers_due.delete();
      for (int s = 0; s < TABLE_SLOTS; s++) begin
        slot_live[s] = 1'b0;
        slot_hash[s] = '0;
        slot_key[s] = '0;
        slot_value[s] = '0;
        slot_skips[s] = 0;
      end
      live_entries = 0;
      fail_count = 0;
      checked = 0;
      full_seen = 0;
      longest_chain = 0;
    end else begin
      // A result can never belong to a request taken in the same cycle,
      // so the output side is handled first.
      if (out_tvalid && out_tready) begin
        got_value = out_tdata[VALUE_BITS-1:0];
        got_slot = out_tdata[VALUE_BITS +: SLOT_W];
        if (answers_due.size() == 0) begin
          $error("result transfer with no request outstanding: status %0d", out_tuser);
          fail_count++;
        end else begin
          due = answers_due.pop_front();
          checked++;
          if (due.status == ST_FULL) full_seen++;
          if (out_tuser !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_tuser);
            fail_count++;
          end
          if (got_value !== due.read_value) begin
            $error("read_value: expected 0x%08h, got 0x%08h", due.read_value, got_value);
            fail_count++;
          end
          if (got_slot !== due.slot_index) begin
            $error("slot_index: expected %0d, got %0d", due.slot_index, got_slot);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        answers_due.push_back(serve(in_tuser, in_tdata[KEY_BITS-1:0],
                                    in_tdata[KEY_BITS +: HASH_BITS],
                                    in_tdata[KEY_BITS+HASH_BITS +: VALUE_BITS]));
      end
    end
    pending = answers_due.size();
  end

endmodule

// File: tb/open_addressing_hash_table_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// open_addressing_hash_table_tb
// Drives get, set and remove requests into the hash table and verdicts.
// ---------------------------------------------------------------------------
// A short directed sequence covers the empty table, zero values, the
// reserved request code, extreme keys and hashes, and collisions whose
// skip counts must survive a remove. Then workloads run one after another:
// each builds a pool of keys whose home slots lie within a chosen spread of a
// random base, inserts them, mixes gets, overwrites and removes on the pool
// with some noise, and finally removes every pool key so that the table is
// empty again. One workload is large enough to fill the table and provoke
// table-full answers, and overwrites of present keys while full. The monitor
// beside the block predicts every result; this module only makes stimulus.
// ---------------------------------------------------------------------------
module open_addressing_hash_table_tb;
  import ohash_pkg::*;

  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int OUT_DW = ((VALUE_BITS + SLOT_W + 7) / 8) * 8;
  localparam int RANDOM_REQUESTS = 650;
  localparam int HOLD_CYCLES = 400;
  // A remove or insert can walk the whole table twice, plus handover.
  localparam int DRAIN_CYCLES = 2 * TABLE_SLOTS + 60;
  localparam int POOL_MAX = 80;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic [1:0]        in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic [1:0]        out_tuser;

  int fail_count;
  int pending;
  int checked;
  int full_seen;
  int longest_chain;

  // Stimulus controls of the sender and the receiver.
  bit in_gaps;
  bit out_gaps;
  bit hold_request;
  int requests_sent;
  int workloads;

  // Key pool of the current workload.
  logic [KEY_BITS-1:0]  pool_key  [POOL_MAX];
  logic [HASH_BITS-1:0] pool_hash [POOL_MAX];
  int                   order     [POOL_MAX];

  open_addressing_hash_table #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ohash_table_monitor #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) table_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .full_seen     (full_seen),
    .longest_chain (longest_chain)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver. It is driven at the falling edge; a hold request keeps
  // out_tready low so that the block fills up and has to stall its input.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready = !out_gaps || ($urandom_range(99) >= 25);
      end
    end
  end

  // Offers one request and returns at the falling edge after its transfer.
  // While idling, tdata and tuser carry rubbish that the block must ignore.
  task automatic offer(input logic [1:0] req, input logic [KEY_BITS-1:0] key,
                       input logic [HASH_BITS-1:0] hash,
                       input logic [VALUE_BITS-1:0] val);
    while (in_gaps && $urandom_range(99) < 25) begin
      in_tvalid = 1'b0;
      in_tdata = {$urandom, $urandom, $urandom};
      in_tuser = 2'($urandom);
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {val, hash, key};
    in_tuser = req;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (req != REQ_NOP) requests_sent++;
  endtask

  // The sender pauses here until every expected result has come back.
  task automatic settle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] stored_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(9))
      0: v = '1;
      1: v = 1;
      default: v = $urandom;
    endcase
    if (v == '0) v = 1;
    return v;
  endfunction

  // One workload: pool_size keys whose home slots lie within spread slots of
  // a random base. With twins set, some keys share a hash with their
  // neighbour or reuse its key under another hash.
  task automatic run_workload(input int pool_size, input int spread, input bit twins);
    int                    base;
    int                    k;
    int                    pick;
    int                    swap_with;
    int                    tmp;
    logic [HASH_BITS-1:0]  h;
    logic [VALUE_BITS-1:0] v;
    base = $urandom_range(TABLE_SLOTS - 1);
    for (int n = 0; n < pool_size; n++) begin
      pool_key[n] = $urandom;
      h = $urandom;
      h[SLOT_W-1:0] = SLOT_W'(base + $urandom_range(spread));
      pool_hash[n] = h;
      if (twins && n > 0 && $urandom_range(7) == 0) pool_hash[n] = pool_hash[n-1];
      if (twins && n > 0 && $urandom_range(11) == 0) pool_key[n] = pool_key[n-1];
      order[n] = n;
    end

    for (int n = 0; n < pool_size; n++)
      offer(REQ_SET, pool_key[n], pool_hash[n], stored_value());

    repeat (2 * pool_size) begin
      pick = $urandom_range(99);
      k = $urandom_range(pool_size - 1);
      if (pick < 40) begin
        offer(REQ_GET, pool_key[k], pool_hash[k], $urandom);
      end else if (pick < 75) begin
        v = ($urandom_range(19) == 0) ? '0 : stored_value();
        offer(REQ_SET, pool_key[k], pool_hash[k], v);
      end else if (pick < 92) begin
        offer(REQ_DEL, pool_key[k], pool_hash[k], $urandom);
      end else if (pick < 95) begin
        // Present key under a hash that differs in one bit.
        offer(REQ_GET, pool_key[k], pool_hash[k] ^ (32'd1 << $urandom_range(31)), $urandom);
      end else if (pick < 97) begin
        offer(REQ_DEL, $urandom, pool_hash[k], $urandom);
      end else if (pick < 99) begin
        offer(REQ_NOP, $urandom, $urandom, $urandom);
      end else begin
        offer(REQ_SET, $urandom, $urandom, '0);
      end
    end

    // Remove every pool key in a shuffled order, leaving the table empty.
    for (int n = pool_size - 1; n > 0; n--) begin
      swap_with = $urandom_range(n);
      tmp = order[n];
      order[n] = order[swap_with];
      order[swap_with] = tmp;
    end
    for (int n = 0; n < pool_size; n++)
      offer(REQ_DEL, pool_key[order[n]], pool_hash[order[n]], $urandom);
    workloads++;
  endtask

  // Run limit, several times the slowest legal run.
  initial begin
    #8_000_000;
    $display("Timed out with %0d results outstanding.", pending);
    $display("** open_addressing_hash_table: FAILED **");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = REQ_GET;
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    hold_request = 1'b0;
    requests_sent = 0;
    workloads = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. The block clears its table after reset with in_tready
    // low, which the handshake in offer simply waits out.
    offer(REQ_GET, '0, '0, '0);                    // empty table, get
    offer(REQ_DEL, '1, '1, '1);                    // empty table, remove
    offer(REQ_SET, 32'h1234_5678, 32'h9abc_def0, '0); // zero value rejected
    offer(REQ_NOP, $urandom, $urandom, $urandom);
    offer(REQ_SET, '0, '0, '1);                    // slot 0
    offer(REQ_SET, '1, '1, 32'd1);                 // last slot
    offer(REQ_GET, '0, '0, '0);
    offer(REQ_GET, '1, '1, '0);
    offer(REQ_SET, '0, '0, '0);                    // zero value on a present key
    offer(REQ_SET, '0, '0, 32'd5);                 // overwrite
    offer(REQ_SET, '0, 32'd64, 32'hdead_beef);     // same home slot, other hash
    offer(REQ_SET, 32'd1, '0, 32'hcafe_f00d);      // same hash, other key
    offer(REQ_GET, 32'd1, '0, '0);
    offer(REQ_GET, '0, 32'd1, '0);                 // right key, wrong hash
    offer(REQ_DEL, '0, '0, '0);                    // clear the head of the chain
    offer(REQ_GET, 32'd1, '0, '0);                 // reached over the cleared slot
    offer(REQ_GET, '0, 32'd64, '0);
    offer(REQ_DEL, 32'd1, '0, '0);
    offer(REQ_DEL, '0, 32'd64, '0);
    offer(REQ_DEL, '0, 32'd64, '0);                // already gone
    offer(REQ_DEL, '1, '1, '0);
    offer(REQ_NOP, '1, '1, '1);
    settle();

    // No idling on either side, and the receiver holds off at the start
    // while the sender keeps offering requests.
    hold_request = 1'b1;
    run_workload(16, 2, 1'b1);
    settle();

    in_gaps = 1'b1;
    out_gaps = 1'b1;
    // More distinct keys than slots: fills the table and answers full.
    run_workload(76, TABLE_SLOTS - 1, 1'b0);
    settle();

    while (requests_sent < RANDOM_REQUESTS + 25) begin
      if ($urandom_range(5) == 0)
        run_workload($urandom_range(6, 20), TABLE_SLOTS - 1, 1'b1);
      else
        run_workload($urandom_range(6, 20), $urandom_range(4), 1'b1);
      settle();
    end

    // Let any stray late result show itself before the verdict.
    out_gaps = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d requests over %0d key workloads; %0d results compared.",
             requests_sent, workloads, checked);
    $display("Table-full answers: %0d, longest insert probe: %0d slots.",
             full_seen, longest_chain);
    if (fail_count == 0 && pending == 0) begin
      $display("** open_addressing_hash_table: PASSED **");
    end else begin
      $display("** open_addressing_hash_table: FAILED **");
    end
    $finish;
  end

endmodule
